FILE: hdl/rcsfd_pkg.sv
package rcsfd_pkg;

	localparam int WORDS_PER_FRAME_DEF = 7;
	localparam int MAX_FRAMES_DEF      = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0] FRAME_GAP_RST = 8'd70;
	localparam logic [7:0] BYTE_GAP_RST  = 8'd3;
	localparam logic [3:0] CH_LIMIT_RST  = 4'd12;

	localparam logic [3:0]  CH_UNUSED   = 4'hF;
	localparam logic [10:0] OFS_10BIT   = 11'd1000;
	localparam logic [11:0] OFS_11BIT   = 12'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_GAP = 2'd0,
		CFG_BYTE_GAP  = 2'd1,
		CFG_CH_LIMIT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_LOST   = 2'd0,
		PH_HEADER = 2'd1,
		PH_HIGH   = 2'd2,
		PH_LOW    = 2'd3
	} sync_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] byte_value;
	} in_t;

	typedef struct packed {
		logic [3:0]  channel;
		logic [11:0] value;
		logic        stored;
		logic        rc_active;
		logic [7:0]  lost_frames;
		logic        last;
	} out_t;

	typedef struct packed {
		logic take;
		logic run_clear;
		logic rd_en;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic run_start;
		logic run_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: hdl/rcsfd_ctrl.sv
module rcsfd_ctrl
	import rcsfd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.run_start) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_d = stat.run_last ? ST_IDLE : ST_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
				cmd.run_clear = in_valid && stat.run_start;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

FILE: hdl/rcsfd_datapath.sv
module rcsfd_datapath
	import rcsfd_pkg::*;
#(
	parameter int WPF  = WORDS_PER_FRAME_DEF,
	parameter int MAXF = MAX_FRAMES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_t                   in_data,
	input  logic                  out_stall,
	output logic                  out_valid,
	output out_t                  out_data,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat
);

	localparam int DEPTH = WPF * MAXF;
	localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW    = $clog2(DEPTH + 1);
	localparam int SLW   = $clog2(2 * WPF);
	localparam int AW    = (SLW > SW) ? SLW : SW;
	localparam int WCW   = $clog2(WPF + 1);
	localparam int CW    = (KW > 5) ? KW : 5;

	// configuration
	logic [7:0] frame_gap_q, byte_gap_q;
	logic [3:0] ch_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_gap_q <= FRAME_GAP_RST;
			byte_gap_q  <= BYTE_GAP_RST;
			ch_limit_q  <= CH_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FRAME_GAP: frame_gap_q <= cfg_data;
				CFG_BYTE_GAP:  byte_gap_q  <= cfg_data;
				CFG_CH_LIMIT:  ch_limit_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// frame sync
	sync_phase_t    phase_q, phase_d;
	logic           resync_q, resync_d;
	logic [7:0]     timer_q, timer_d;
	logic [WCW-1:0] wcnt_q, wcnt_d, wcnt_inc;
	logic [1:0]     fcnt_q, fcnt_d, fcnt_inc;
	logic           upper_q, upper_d;
	logic [7:0]     held_q, held_d;
	logic [7:0]     lost_q, lost_d;
	logic           penc_q, penc_d;
	logic [1:0]     pfr_q, pfr_d;
	logic           aenc_q, aenc_d;
	logic [AW-1:0]  slot;
	logic           mem_we;
	logic           run_start;
	logic [7:0]     c;

	assign c        = in_data.byte_value;
	assign wcnt_inc = wcnt_q + WCW'(1);
	assign fcnt_inc = fcnt_q + 2'd1;
	assign slot     = AW'(wcnt_q) + (upper_q ? AW'(WPF) : AW'(0));

	always_comb begin
		phase_d   = phase_q;
		resync_d  = resync_q;
		timer_d   = timer_q;
		wcnt_d    = wcnt_q;
		fcnt_d    = fcnt_q;
		upper_d   = upper_q;
		held_d    = held_q;
		lost_d    = lost_q;
		penc_d    = penc_q;
		pfr_d     = pfr_q;
		aenc_d    = aenc_q;
		mem_we    = 1'b0;
		run_start = 1'b0;
		if (in_data.mode) begin
			if (timer_q != 8'd0) timer_d = timer_q - 8'd1;
		end else if (resync_q || (phase_q == PH_LOST && timer_q != 8'd0)) begin
			// early byte: restart the quiet wait
			resync_d = 1'b0;
			timer_d  = frame_gap_q;
			phase_d  = PH_LOST;
			wcnt_d   = '0;
			fcnt_d   = '0;
			upper_d  = 1'b0;
		end else if (phase_q == PH_LOST) begin
			lost_d  = c;
			phase_d = PH_HEADER;
			timer_d = byte_gap_q;
		end else if (timer_q == 8'd0) begin
			// late byte inside a frame: drop it and resync
			resync_d = 1'b1;
			timer_d  = frame_gap_q;
		end else if (phase_q == PH_HEADER) begin
			penc_d  = c[4];
			pfr_d   = (32'(c[1:0]) > MAXF) ? 2'(MAXF) : c[1:0];
			phase_d = PH_HIGH;
			timer_d = byte_gap_q;
		end else if (phase_q == PH_HIGH) begin
			held_d = c;
			if (wcnt_q == '0) upper_d = c[7];
			phase_d = PH_LOW;
			timer_d = byte_gap_q;
		end else begin
			phase_d = PH_HIGH;
			timer_d = byte_gap_q;
			mem_we  = (32'(slot) < DEPTH);
			wcnt_d  = wcnt_inc;
			if (wcnt_inc == WCW'(WPF)) begin
				fcnt_d = fcnt_inc;
				if (pfr_q != 2'd0 && fcnt_inc == pfr_q) begin
					run_start = 1'b1;
					fcnt_d    = 2'd0;
				end
				aenc_d  = penc_q;
				phase_d = PH_LOST;
				wcnt_d  = '0;
				upper_d = 1'b0;
				timer_d = frame_gap_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LOST;
			resync_q <= 1'b1;
			timer_q  <= 8'd0;
			wcnt_q   <= '0;
			fcnt_q   <= 2'd0;
			upper_q  <= 1'b0;
			held_q   <= 8'd0;
			lost_q   <= 8'd0;
			penc_q   <= 1'b0;
			pfr_q    <= 2'd0;
			aenc_q   <= 1'b0;
		end else if (cmd.take) begin
			phase_q  <= phase_d;
			resync_q <= resync_d;
			timer_q  <= timer_d;
			wcnt_q   <= wcnt_d;
			fcnt_q   <= fcnt_d;
			upper_q  <= upper_d;
			held_q   <= held_d;
			lost_q   <= lost_d;
			penc_q   <= penc_d;
			pfr_q    <= pfr_d;
			aenc_q   <= aenc_d;
		end
	end

	// word store
	logic [15:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [15:0]    rd_q;
	logic           rd_vld_q;
	logic [KW-1:0]  k_q, total_q, k_inc;

	assign k_inc = k_q + KW'(1);

	always_ff @(posedge clk) begin
		if (cmd.take && mem_we) mem[slot[SW-1:0]] <= {held_q, c};
		if (cmd.rd_en) rd_q <= mem[k_q[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.take && mem_we) vld_q[slot[SW-1:0]] <= 1'b1;
			if (cmd.rd_en) rd_vld_q <= vld_q[k_q[SW-1:0]];
		end
	end

	// decode run
	logic [15:0]   w;
	logic [3:0]    ch;
	logic          ok;
	logic [11:0]   val;
	logic [KW-1:0] dec_q, dec_n;
	logic [3:0]    hi_q, hi_n;
	logic          is_last;
	logic          out_vq;
	out_t          out_q;

	assign w       = rd_vld_q ? rd_q : 16'd0;
	assign ch      = aenc_q ? w[14:11] : w[13:10];
	assign ok      = (ch < ch_limit_q);
	assign val     = !ok ? 12'd0 :
	                 aenc_q ? (12'(w[10:0]) + OFS_11BIT) :
	                 {(11'(w[9:0]) + OFS_10BIT), 1'b0};
	assign dec_n   = dec_q + KW'(ok);
	assign hi_n    = (ch != CH_UNUSED && ch > hi_q) ? ch : hi_q;
	assign is_last = (k_inc == total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			total_q <= '0;
			dec_q   <= '0;
			hi_q    <= 4'd0;
		end else if (cmd.run_clear) begin
			k_q     <= '0;
			total_q <= KW'(WPF) * KW'(pfr_q);
			dec_q   <= '0;
		end else if (cmd.emit) begin
			k_q   <= k_inc;
			dec_q <= dec_n;
			hi_q  <= hi_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vq <= 1'b0;
		end else if (cmd.emit) begin
			out_vq <= 1'b1;
		end else if (!out_stall) begin
			out_vq <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.channel     <= ch;
			out_q.value       <= val;
			out_q.stored      <= ok;
			out_q.rc_active   <= is_last && (CW'(dec_n) >= CW'(hi_n) + CW'(1));
			out_q.lost_frames <= lost_q;
			out_q.last        <= is_last;
		end
	end

	assign out_valid = out_vq;
	assign out_data  = out_q;

	assign stat.run_start = run_start;
	assign stat.run_last  = is_last;
	assign stat.out_free  = !out_vq || !out_stall;

endmodule

FILE: hdl/rc_satellite_frame_decoder.sv
// Serial frame decoder for an RC satellite receiver.
// Input requests on in_valid/in_stall carry either a received byte
// (mode 0) or a timer tick (mode 1). A request is taken when presented
// while the block is not decoding; ticks count the gap timer down, bytes
// walk the frame sync and fill the word store.
// The low byte that completes the expected number of frames starts a
// decode run: one result request per word of the run on out_valid/out_stall,
// the final one flagged with last and carrying rc_active. Each word is
// read from the store (it has a single registered read port) and then
// decoded before the next is read; in_stall stays high during the run.
// Results go through an output register, so input is taken again while the
// last result still waits. A stalled receiver holds the run at its current
// word. Configuration writes take effect at the clock edge, with no wait.
// Reset returns the registers to their defaults, empties the word store
// (unwritten words read as zero) and forces a resync on the first byte.
module rc_satellite_frame_decoder
	import rcsfd_pkg::*;
#(
	parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF,
	parameter int MAX_FRAMES      = MAX_FRAMES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	rcsfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rcsfd_datapath #(
		.WPF  (WORDS_PER_FRAME),
		.MAXF (MAX_FRAMES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
